// ===== rtl/trmb_pkg.sv =====
`default_nettype none

package trmb_pkg;

  localparam int CFG_AW  = 3;
  localparam int BOUND_W = 32;
  localparam int REM_W   = 5;
  localparam int CITY_W  = 4;

  // register index, taken from paddr[2]
  localparam logic REG_CITY_COUNT = 1'b0;

  typedef enum logic [1:0] {
    PASS_MOD,
    PASS_ROW,
    PASS_COL
  } pass_e;

endpackage

`default_nettype wire

// ===== rtl/trmb_cell.sv =====
`default_nettype none

module trmb_cell #(
  parameter int W = 24
) (
  input  wire logic         clk_i,
  input  wire logic         shift_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule

`default_nettype wire

// ===== rtl/tsp_reduced_matrix_bound.sv =====
// Channel  Signals                                          Direction
// -------  -----------------------------------------------  ---------
// in       in_valid_i/in_ready_o, mode/row/col/cost/last/city  in
// out      out_valid_o/out_ready_i, lower_bound/infinite/rem/complete  out
// cfg      psel/penable/pwrite/paddr/pwdata/prdata/pready      in/out
//
// The cost matrix circulates through a ring of MAX_CITIES^2 cells; one
// processing head sees one entry per cycle, so one sweep covers all N = MAX_CITIES^2 entries.
// A plain load runs only the modify sweep. A last load or an extend runs
// the modify/row-min sweep, the row-subtract/col-min sweep, the col-subtract
// sweep and the visited count. A rejected extend runs only the visited count.
// Reset clears control and path state; matrix cells are not reset.
// A finished beat waits in the output register; a new beat is taken meanwhile.
`default_nettype none

module tsp_reduced_matrix_bound
  import trmb_pkg::*;
#(
  parameter int MAX_CITIES = 16,
  parameter int COST_BITS  = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CFG_AW-1:0]   paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                mode_i,
  input  wire logic [CITY_W-1:0]   row_i,
  input  wire logic [CITY_W-1:0]   col_i,
  input  wire logic [23:0]         cost_i,
  input  wire logic                last_entry_i,
  input  wire logic [CITY_W-1:0]   city_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [BOUND_W-1:0]  lower_bound_o,
  output logic                     bound_infinite_o,
  output logic      [REM_W-1:0]    remaining_o,
  output logic                     path_complete_o
);

  localparam int IW    = $clog2(MAX_CITIES);
  localparam int NW    = $clog2(MAX_CITIES + 1);
  localparam int NCELL = MAX_CITIES * MAX_CITIES;
  localparam logic [COST_BITS-1:0] INF = '1;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_CITIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_CNT,
    ST_FIN
  } state_e;

  state_e            state_q;
  pass_e             pass_q;
  logic [IW-1:0]     rc_q, cc_q;
  logic [4:0]        city_count_q;
  logic [NW-1:0]     n_w;

  logic              mode_q, last_q, lin_q, prev_q;
  logic [IW-1:0]     lr_q, lc_q, a_q, b_q;
  logic [COST_BITS-1:0] lcost_q;
  logic [MAX_CITIES-1:0] visited_q;
  logic [IW-1:0]     last_city_q;
  logic [NW-1:0]     plen_q;
  logic [BOUND_W-1:0] bound_q;
  logic              binf_q;
  logic [NW-1:0]     cnt_q, cnt_d;

  logic [COST_BITS-1:0] run_min_q;
  logic [COST_BITS-1:0] rowmin_q [MAX_CITIES];
  logic [COST_BITS-1:0] colmin_q [MAX_CITIES];

  logic              out_valid_q;
  logic [BOUND_W-1:0] out_bound_q;
  logic              out_inf_q;
  logic [REM_W-1:0]  out_rem_q;
  logic              out_done_q;

  // ---------------- configuration ----------------
  always_comb begin
    if (city_count_q < 5'd2) begin
      n_w = NW'(2);
    end else if (32'(city_count_q) > 32'(MAX_CITIES)) begin
      n_w = NW'(MAX_CITIES);
    end else begin
      n_w = NW'(city_count_q);
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CITY_COUNT) ? 32'(city_count_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      city_count_q <= 5'd16;
    end else if (psel && penable && pwrite && paddr[2] == REG_CITY_COUNT) begin
      city_count_q <= pwdata[4:0];
    end
  end

  // ---------------- cell ring ----------------
  logic [COST_BITS-1:0] cell_q [NCELL];
  logic [COST_BITS-1:0] head_d;
  logic                 shift_w;

  assign shift_w = (state_q == ST_RUN);

  for (genvar k = 0; k < NCELL; k++) begin : g_ring
    logic [COST_BITS-1:0] d_w;
    if (k == NCELL - 1) begin : g_tail
      assign d_w = head_d;
    end else begin : g_mid
      assign d_w = cell_q[k+1];
    end
    trmb_cell #(.W(COST_BITS)) u_cell (
      .clk_i  (clk_i),
      .shift_i(shift_w),
      .d_i    (d_w),
      .q_o    (cell_q[k])
    );
  end

  // ---------------- processing head ----------------
  logic [COST_BITS-1:0] v_w, m_w, cur_w, nmin_w, ccur_w, ncol_w;
  logic                 ra_w, ca_w, act_w;
  logic                 add_en_w, force_inf_w;
  logic [COST_BITS-1:0] add_v_w;
  logic [BOUND_W:0]     sum_w;

  assign v_w   = cell_q[0];
  assign ra_w  = NW'(rc_q) < n_w;
  assign ca_w  = NW'(cc_q) < n_w;
  assign act_w = ra_w && ca_w;

  always_comb begin
    head_d      = v_w;
    m_w         = INF;
    add_en_w    = 1'b0;
    force_inf_w = 1'b0;
    add_v_w     = '0;
    case (pass_q)
      PASS_MOD: begin
        if (!mode_q) begin
          if (lin_q && rc_q == lr_q && cc_q == lc_q) begin
            head_d = (lr_q == lc_q) ? INF : lcost_q;
          end
        end else begin
          if (prev_q && rc_q == a_q && cc_q == b_q) begin
            if (v_w == INF) begin
              force_inf_w = 1'b1;
            end else begin
              add_en_w = 1'b1;
              add_v_w  = v_w;
            end
          end
          if ((prev_q && ((rc_q == a_q && ca_w) || (cc_q == b_q && ra_w)))
              || (rc_q == b_q && visited_q[cc_q])) begin
            head_d = INF;
          end
        end
      end
      PASS_ROW: begin
        m_w = rowmin_q[rc_q];
        if (act_w && m_w != INF && v_w != INF) begin
          head_d = v_w - m_w;
        end
        if (cc_q == '0 && ra_w && m_w != INF) begin
          add_en_w = 1'b1;
          add_v_w  = m_w;
        end
      end
      PASS_COL: begin
        m_w = colmin_q[cc_q];
        if (act_w && m_w != INF && v_w != INF) begin
          head_d = v_w - m_w;
        end
        if (rc_q == '0 && ca_w && m_w != INF) begin
          add_en_w = 1'b1;
          add_v_w  = m_w;
        end
      end
      default: ;
    endcase
  end

  assign cur_w  = (cc_q == '0) ? INF : run_min_q;
  assign nmin_w = (act_w && head_d < cur_w) ? head_d : cur_w;
  assign ccur_w = (rc_q == '0) ? INF : colmin_q[cc_q];
  assign ncol_w = (act_w && head_d < ccur_w) ? head_d : ccur_w;
  assign sum_w  = {1'b0, bound_q} + (BOUND_W+1)'(add_v_w);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN) begin
      if (pass_q == PASS_MOD) begin
        run_min_q <= nmin_w;
        if (cc_q == LAST_IDX) begin
          rowmin_q[rc_q] <= nmin_w;
        end
      end
      if (pass_q == PASS_ROW) begin
        colmin_q[cc_q] <= ncol_w;
      end
    end
  end

  // ---------------- input decode ----------------
  logic [31:0]   row32, col32, city32, cost32;
  logic [IW-1:0] bidx_w;
  logic          bad_w;

  assign row32  = 32'(row_i);
  assign col32  = 32'(col_i);
  assign city32 = 32'(city_i);
  assign cost32 = 32'(cost_i);
  assign bidx_w = city32[IW-1:0];
  assign bad_w  = (city32 >= 32'(n_w)) || visited_q[bidx_w];

  assign cnt_d = (ca_w && visited_q[cc_q]) ? cnt_q + NW'(1) : cnt_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      lr_q    <= row32[IW-1:0];
      lc_q    <= col32[IW-1:0];
      lcost_q <= cost32[COST_BITS-1:0];
    end
  end

  // ---------------- control ----------------
  logic [NW-1:0] rem_w;
  assign rem_w = n_w - cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= PASS_MOD;
      rc_q        <= '0;
      cc_q        <= '0;
      mode_q      <= 1'b0;
      last_q      <= 1'b0;
      lin_q       <= 1'b0;
      prev_q      <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      visited_q   <= '0;
      last_city_q <= '0;
      plen_q      <= '0;
      bound_q     <= '0;
      binf_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_bound_q <= '0;
      out_inf_q   <= 1'b0;
      out_rem_q   <= '0;
      out_done_q  <= 1'b0;
    end else begin
      if (out_ready_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            mode_q <= mode_i;
            last_q <= last_entry_i;
            pass_q <= PASS_MOD;
            cnt_q  <= '0;
            if (!mode_i) begin
              lin_q   <= (row32 < 32'(MAX_CITIES)) && (col32 < 32'(MAX_CITIES));
              state_q <= ST_RUN;
              if (last_entry_i) begin
                visited_q   <= '0;
                last_city_q <= '0;
                plen_q      <= '0;
                bound_q     <= '0;
                binf_q      <= 1'b0;
              end
            end else if (bad_w) begin
              state_q <= ST_CNT;
            end else begin
              a_q                 <= last_city_q;
              prev_q              <= (plen_q != '0);
              b_q                 <= bidx_w;
              visited_q[bidx_w]   <= 1'b1;
              last_city_q         <= bidx_w;
              plen_q              <= plen_q + NW'(1);
              state_q             <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (force_inf_w) begin
            binf_q  <= 1'b1;
            bound_q <= '1;
          end else if (add_en_w && !binf_q) begin
            if (sum_w[BOUND_W]) begin
              binf_q  <= 1'b1;
              bound_q <= '1;
            end else begin
              bound_q <= sum_w[BOUND_W-1:0];
            end
          end
          if (cc_q == LAST_IDX) begin
            cc_q <= '0;
            if (rc_q == LAST_IDX) begin
              rc_q <= '0;
              case (pass_q)
                PASS_MOD: begin
                  if (!mode_q && !last_q) begin
                    state_q <= ST_IDLE;
                  end else begin
                    pass_q <= PASS_ROW;
                  end
                end
                PASS_ROW: pass_q <= PASS_COL;
                default:  state_q <= ST_CNT;
              endcase
            end else begin
              rc_q <= rc_q + IW'(1);
            end
          end else begin
            cc_q <= cc_q + IW'(1);
          end
        end
        ST_CNT: begin
          // tally visited cities below n, one per cycle
          cnt_q <= cnt_d;
          if (cc_q == LAST_IDX) begin
            cc_q    <= '0;
            state_q <= ST_FIN;
          end else begin
            cc_q <= cc_q + IW'(1);
          end
        end
        ST_FIN: begin
          // hold until the previous result beat has left
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_bound_q <= binf_q ? '1 : bound_q;
            out_inf_q   <= binf_q;
            out_rem_q   <= REM_W'(rem_w);
            out_done_q  <= (rem_w == '0);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign lower_bound_o    = out_bound_q;
  assign bound_infinite_o = out_inf_q;
  assign remaining_o      = out_rem_q;
  assign path_complete_o  = out_done_q;

  // ---------------- assertions ----------------
  a_ring_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RUN && state_q != ST_CNT) |-> (rc_q == '0 && cc_q == '0))
    else $error("sweep counters not at home outside a sweep");

  a_inf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    binf_q |-> (bound_q == '1))
    else $error("infinite bound without saturated accumulator");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
    else $error("accepted beat did not start work");

endmodule

`default_nettype wire

// ===== sim/tsp_reduced_matrix_bound_tb.sv =====
`default_nettype none

module tsp_reduced_matrix_bound_tb;
  import trmb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SIDE      = 16;
  localparam logic [23:0] COST_INF  = 24'hFF_FFFF;
  localparam bit          MODE_LOAD = 1'b0;
  localparam bit          MODE_EXT  = 1'b1;
  localparam int          ITEMS     = 1170;
  localparam int          SETTLE    = 900;

  class bound_scoreboard;
    typedef struct packed {
      logic [31:0] bound;
      logic        inf;
      logic [4:0]  rem;
      logic        done;
    } node_t;

    node_t       pending[$];
    int          errors;
    logic [23:0] mat[SIDE][SIDE];
    logic [15:0] seen;
    logic [3:0]  prev;
    int unsigned hops;
    logic [31:0] acc;
    bit          sat;
    logic [4:0]  count_reg;

    function new();
      seen = '0;
      prev = '0;
      hops = 0;
      acc = '0;
      sat = 0;
      count_reg = 5'd16;
      errors = 0;
    endfunction

    function int side_n();
      if (count_reg < 2) return 2;
      if (count_reg > SIDE) return SIDE;
      return int'(count_reg);
    endfunction

    function void add_bound(logic [31:0] v);
      logic [32:0] s;
      if (sat) return;
      s = {1'b0, acc} + {1'b0, v};
      if (s[32]) begin
        sat = 1;
        acc = '1;
      end else begin
        acc = s[31:0];
      end
    endfunction

    function void reduce_matrix();
      int n;
      logic [23:0] m;
      n = side_n();
      for (int i = 0; i < n; i++) begin
        m = COST_INF;
        for (int j = 0; j < n; j++) if (mat[i][j] < m) m = mat[i][j];
        if (m != COST_INF) begin
          add_bound({8'd0, m});
          for (int j = 0; j < n; j++) if (mat[i][j] != COST_INF) mat[i][j] -= m;
        end
      end
      for (int j = 0; j < n; j++) begin
        m = COST_INF;
        for (int i = 0; i < n; i++) if (mat[i][j] < m) m = mat[i][j];
        if (m != COST_INF) begin
          add_bound({8'd0, m});
          for (int i = 0; i < n; i++) if (mat[i][j] != COST_INF) mat[i][j] -= m;
        end
      end
    endfunction

    function void post_node();
      node_t r;
      int n;
      int left;
      n = side_n();
      left = n;
      for (int i = 0; i < n; i++) if (seen[i]) left--;
      r.bound = sat ? 32'hFFFF_FFFF : acc;
      r.inf = sat;
      r.rem = left[4:0];
      r.done = (left == 0);
      pending.insert(pending.size(), r);
    endfunction

    function void note_beat(bit mode, logic [3:0] r, logic [3:0] c, logic [23:0] cost,
                            bit last, logic [3:0] city);
      int n;
      logic [23:0] e;
      n = side_n();
      if (mode == MODE_LOAD) begin
        mat[r][c] = (r == c) ? COST_INF : cost;
        if (!last) return;
        seen = '0;
        prev = '0;
        hops = 0;
        acc = '0;
        sat = 0;
        reduce_matrix();
        post_node();
        return;
      end
      if (city >= n || seen[city]) begin
        post_node();
        return;
      end
      if (hops >= 1) begin
        e = mat[prev][city];
        if (e == COST_INF) begin
          sat = 1;
          acc = '1;
        end else begin
          add_bound({8'd0, e});
        end
        for (int i = 0; i < n; i++) begin
          mat[prev][i] = COST_INF;
          mat[i][city] = COST_INF;
        end
      end
      seen[city] = 1'b1;
      for (int i = 0; i < SIDE; i++) if (seen[i]) mat[city][i] = COST_INF;
      prev = city;
      hops++;
      reduce_matrix();
      post_node();
    endfunction

    function void check_beat(logic [31:0] bound, logic inf, logic [4:0] rem, logic done);
      node_t x;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: bound %h inf %b rem %0d done %b",
                                   bound, inf, rem, done);
        return;
      end
      x = pending.pop_front();
      if (bound !== x.bound || inf !== x.inf || rem !== x.rem || done !== x.done) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp bound %h inf %b rem %0d done %b, got %h %b %0d %b",
                   x.bound, x.inf, x.rem, x.done, bound, inf, rem, done);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        mode_i;
  logic [3:0]  row_i;
  logic [3:0]  col_i;
  logic [23:0] cost_i;
  logic        last_entry_i;
  logic [3:0]  city_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] lower_bound_o;
  logic        bound_infinite_o;
  logic [4:0]  remaining_o;
  logic        path_complete_o;

  bound_scoreboard sb;
  int gap_pct;
  int stall_pct;
  int sent;

  tsp_reduced_matrix_bound u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .cost_i          (cost_i),
    .last_entry_i    (last_entry_i),
    .city_i          (city_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .lower_bound_o   (lower_bound_o),
    .bound_infinite_o(bound_infinite_o),
    .remaining_o     (remaining_o),
    .path_complete_o (path_complete_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("FAIL tsp_reduced_matrix_bound");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_beat(mode_i, row_i, col_i, cost_i, last_entry_i, city_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_beat(lower_bound_o, bound_infinite_o, remaining_o, path_complete_o);
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send(bit mode, logic [3:0] r, logic [3:0] c, logic [23:0] cost,
                      bit last, logic [3:0] city);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    mode_i = mode;
    row_i = r;
    col_i = c;
    cost_i = cost;
    last_entry_i = last;
    city_i = city;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic extend(logic [3:0] city);
    send(MODE_EXT, 4'($urandom), 4'($urandom), 24'($urandom), 1'($urandom), city);
  endtask

  // hold the sender until every expected beat is back, then let the core drain
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_city_count(logic [4:0] v);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {REG_CITY_COUNT, 2'b00};
    pwdata = {27'd0, v};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.count_reg = v;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic [23:0] pick_cost();
    case ($urandom_range(9))
      0: return COST_INF;
      1: return 24'd0;
      2: return 24'($urandom);
      3: return 24'hFF_FFFE - 24'($urandom_range(255));
      default: return 24'($urandom_range(100));
    endcase
  endfunction

  initial begin
    int n;
    int k;
    int v;
    int tour[$];
    logic [3:0] r;
    logic [3:0] c;

    sb = new();
    gap_pct = 28;
    stall_pct = 63;
    sent = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    mode_i = 1'b0;
    row_i = '0;
    col_i = '0;
    cost_i = '0;
    last_entry_i = 1'b0;
    city_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // write every cell once so no later read sees an unwritten entry
    write_city_count(5'd16);
    for (int i = 0; i < SIDE; i++)
      for (int j = 0; j < SIDE; j++)
        send(MODE_LOAD, 4'(i), 4'(j), pick_cost(), (i == SIDE - 1 && j == SIDE - 1), 4'd0);

    extend(4'd0);
    extend(4'd0);
    extend(4'd15);
    send(MODE_LOAD, 4'd15, 4'd3, COST_INF, 1'b0, 4'd0);
    extend(4'd3);
    extend(4'd3);
    send(MODE_LOAD, 4'd5, 4'd5, 24'd0, 1'b1, 4'd0);
    send(MODE_LOAD, 4'd1, 4'd0, 24'd0, 1'b0, 4'd0);
    send(MODE_LOAD, 4'd0, 4'd1, 24'hFF_FFFE, 1'b1, 4'd0);
    drain();
    write_city_count(5'd2);
    send(MODE_LOAD, 4'd0, 4'd1, 24'd7, 1'b1, 4'd0);
    extend(4'd1);
    extend(4'd9);
    extend(4'd0);
    extend(4'd1);

    while (sent < ITEMS) begin
      if (sent < ITEMS / 3) begin
        gap_pct = 28;
        stall_pct = 63;
      end else if (sent < 2 * ITEMS / 3) begin
        gap_pct = 63;
        stall_pct = 28;
      end else begin
        gap_pct = 0;
        stall_pct = 0;
      end
      case ($urandom_range(9))
        0: v = $urandom_range(1);
        1: v = 16;
        2: v = $urandom_range(17, 31);
        3: v = 2;
        default: v = $urandom_range(3, 6);
      endcase
      drain();
      write_city_count(5'(v));
      n = sb.side_n();
      k = $urandom_range(1, n * n);
      if (k > ITEMS - sent) k = ITEMS - sent;
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(3) != 0) begin
          r = 4'($urandom_range(n - 1));
          c = 4'($urandom_range(n - 1));
        end else begin
          r = 4'($urandom);
          c = 4'($urandom);
        end
        send(MODE_LOAD, r, c, pick_cost(), i == k - 1, 4'($urandom));
      end
      tour.delete();
      for (int i = 0; i < n; i++) tour.insert(tour.size(), i);
      tour.shuffle();
      foreach (tour[i]) begin
        if ($urandom_range(9) == 0) extend(4'($urandom));
        extend(4'(tour[i]));
      end
      if ($urandom_range(3) == 0) extend(4'($urandom));
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS tsp_reduced_matrix_bound");
    end else begin
      $display("FAIL tsp_reduced_matrix_bound");
    end
    $finish;
  end

endmodule

`default_nettype wire
